[design/crc_pkg.sv]
package crc_pkg;

  localparam int unsigned MAX_SIDE    = 256;
  localparam int unsigned FRAC_BITS   = 8;
  localparam int unsigned SIDE_W      = $clog2(MAX_SIDE);
  localparam int unsigned ADDR_W      = 2 * SIDE_W;
  localparam int unsigned COORD_W     = 20;
  localparam int unsigned SQ_W        = 2 * COORD_W;
  localparam int unsigned SUM_W       = SQ_W + 1;
  localparam int unsigned SIZE_W      = 9;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(MAX_SIDE);
  localparam logic [CHAR_W-1:0] BG_RESET   = 8'd32;

  localparam logic OP_DRAW = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_RADIUS = 2'd1;
  localparam logic [1:0] STATUS_BLOCKED    = 2'd2;

  typedef enum logic [1:0] {
    CLS_DRAW,
    CLS_READ,
    CLS_REJECT,
    CLS_BLOCKED
  } cls_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ
  } st_e;

  typedef struct packed {
    logic                      operation;
    logic                      filled;
    logic signed [COORD_W-1:0] ctr_x;
    logic signed [COORD_W-1:0] ctr_y;
    logic signed [COORD_W-1:0] radius;
    logic [CHAR_W-1:0]         paint_char;
    logic [SIDE_W-1:0]         pixel_x;
    logic [SIDE_W-1:0]         pixel_y;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] pixel_value;
    logic [1:0]        status;
  } out_word_t;

  typedef struct packed {
    cls_e                      cls;
    logic                      filled;
    logic signed [COORD_W-1:0] ctr_x;
    logic signed [COORD_W-1:0] ctr_y;
    logic signed [COORD_W-1:0] radius;
    logic [CHAR_W-1:0]         paint_char;
    logic [SIDE_W-1:0]         pixel_x;
    logic [SIDE_W-1:0]         pixel_y;
  } q_entry_t;

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [CHAR_W-1:0] bg;
  } cfg_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_stat_t;

endpackage

[design/crc_front.sv]
module crc_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  crc_pkg::in_word_t   in_word_i,
  input  crc_pkg::back_stat_t stat_i,
  output crc_pkg::q_entry_t   head_o,
  output logic                head_valid_o
);
  import crc_pkg::*;

  q_entry_t          queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  logic              err_q, err_d;
  logic              accept;
  logic              bad_radius;
  q_entry_t          entry;

  assign in_ready_o   = (count_q != QCNT_W'(QUEUE_DEPTH)) && !stat_i.clearing;
  assign accept       = in_valid_i && in_ready_o;
  assign head_valid_o = (count_q != '0);
  assign head_o       = queue_q[rd_ptr_q];
  assign bad_radius   = in_word_i.radius[COORD_W-1] || (in_word_i.radius == '0);

  always_comb begin
    entry.filled     = in_word_i.filled;
    entry.ctr_x      = in_word_i.ctr_x;
    entry.ctr_y      = in_word_i.ctr_y;
    entry.radius     = in_word_i.radius;
    entry.paint_char = in_word_i.paint_char;
    entry.pixel_x    = in_word_i.pixel_x;
    entry.pixel_y    = in_word_i.pixel_y;
    if (err_q) begin
      entry.cls = CLS_BLOCKED;
    end else if (in_word_i.operation == OP_READ) begin
      entry.cls = CLS_READ;
    end else if (bad_radius) begin
      entry.cls = CLS_REJECT;
    end else begin
      entry.cls = CLS_DRAW;
    end
  end

  always_comb begin
    err_d    = err_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (accept) begin
      if (entry.cls == CLS_REJECT) begin
        err_d = 1'b1;
      end
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (stat_i.pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (accept && !stat_i.pop) begin
      count_d = count_q + 1'b1;
    end else if (!accept && stat_i.pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q    <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      err_q    <= err_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      queue_q[wr_ptr_q] <= entry;
    end
  end

endmodule

[design/crc_back.sv]
module crc_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  crc_pkg::cfg_t       cfg_i,
  input  crc_pkg::q_entry_t   head_i,
  input  logic                head_valid_i,
  output crc_pkg::back_stat_t stat_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output crc_pkg::out_word_t  out_word_o
);
  import crc_pkg::*;

  logic [CHAR_W-1:0] canvas_mem [2**ADDR_W];
  logic [CHAR_W-1:0] rd_data_q;

  st_e               state_q, state_d;
  q_entry_t          entry_q;
  logic [SIDE_W-1:0] x_q, y_q;
  logic [ADDR_W-1:0] clr_q;
  logic [SQ_W-1:0]   r2_q, s2_q;
  logic              s_neg_q;
  logic              v1_q, v2_q, v3_q;
  logic [COORD_W-1:0] adx_q, ady_q;
  logic [SQ_W-1:0]   dx2_q, dy2_q;
  logic [SUM_W-1:0]  d2_q;
  logic [ADDR_W-1:0] a1_q, a2_q, a3_q;
  logic              in_range_q;
  logic              out_valid_q;
  out_word_t         out_word_q;

  logic [SIZE_W-1:0] w_use, h_use;
  logic              x_end, y_end, last_px, pipe_empty, size_empty;
  logic              pop, rd_en, load_out, wr_en, hit;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [CHAR_W-1:0] wr_data, rd_val;
  out_word_t         out_d;
  logic signed [COORD_W:0] dx, dy, s_val;
  logic [COORD_W-1:0] r_mag, s_mag;

  assign w_use = (cfg_i.width > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : cfg_i.width;
  assign h_use = (cfg_i.height > SIZE_W'(MAX_SIDE)) ? SIZE_W'(MAX_SIDE) : cfg_i.height;
  assign size_empty = (w_use == '0) || (h_use == '0);
  assign x_end      = ({1'b0, x_q} == w_use - 1'b1);
  assign y_end      = ({1'b0, y_q} == h_use - 1'b1);
  assign last_px    = x_end && y_end;
  assign pipe_empty = !(v1_q || v2_q || v3_q);

  assign dx = {entry_q.ctr_x[COORD_W-1], entry_q.ctr_x}
            - $signed(({{(COORD_W + 1 - SIDE_W){1'b0}}, x_q} << FRAC_BITS));
  assign dy = {entry_q.ctr_y[COORD_W-1], entry_q.ctr_y}
            - $signed(({{(COORD_W + 1 - SIDE_W){1'b0}}, y_q} << FRAC_BITS));
  assign r_mag = entry_q.radius[COORD_W-1:0];
  assign s_val = {entry_q.radius[COORD_W-1], entry_q.radius}
               - $signed((COORD_W + 1)'(1) << FRAC_BITS);
  assign s_mag = s_val[COORD_W-1:0];

  assign hit = v3_q && (d2_q <= {1'b0, r2_q})
            && (entry_q.filled || s_neg_q || (d2_q > {1'b0, s2_q}));

  assign rd_addr = {head_i.pixel_y, head_i.pixel_x};
  assign rd_val  = in_range_q ? rd_data_q : '0;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_q == '1) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_valid_i && !out_valid_q) begin
          if (head_i.cls == CLS_DRAW) begin
            state_d = ST_SETUP;
          end else if (head_i.cls == CLS_READ) begin
            state_d = ST_READ;
          end
        end
      end
      ST_SETUP: state_d = size_empty ? ST_DRAIN : ST_SWEEP;
      ST_SWEEP: begin
        if (last_px) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (pipe_empty) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    pop      = 1'b0;
    rd_en    = 1'b0;
    load_out = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = a3_q;
    wr_data  = entry_q.paint_char;
    out_d    = '{pixel_value: '0, status: STATUS_OK};
    unique case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
      end
      ST_IDLE: begin
        pop = head_valid_i && !out_valid_q;
        if (pop) begin
          unique case (head_i.cls)
            CLS_READ:    rd_en = 1'b1;
            CLS_REJECT: begin
              load_out     = 1'b1;
              out_d.status = STATUS_BAD_RADIUS;
            end
            CLS_BLOCKED: begin
              load_out     = 1'b1;
              out_d.status = STATUS_BLOCKED;
            end
            default: ;
          endcase
        end
      end
      ST_SETUP, ST_SWEEP: wr_en = hit;
      ST_DRAIN: begin
        wr_en    = hit;
        load_out = pipe_empty;
      end
      ST_READ: begin
        load_out          = 1'b1;
        out_d.pixel_value = (rd_val == '0) ? cfg_i.bg : rd_val;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (state_q == ST_SETUP) begin
        x_q <= '0;
        y_q <= '0;
      end else if (state_q == ST_SWEEP) begin
        if (x_end) begin
          x_q <= '0;
          y_q <= y_q + 1'b1;
        end else begin
          x_q <= x_q + 1'b1;
        end
      end
      v1_q <= (state_q == ST_SWEEP);
      v2_q <= v1_q;
      v3_q <= v2_q;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      entry_q    <= head_i;
      in_range_q <= ({1'b0, head_i.pixel_x} < w_use) && ({1'b0, head_i.pixel_y} < h_use);
    end
    if (state_q == ST_SETUP) begin
      r2_q    <= r_mag * r_mag;
      s_neg_q <= s_val[COORD_W];
      s2_q    <= s_val[COORD_W] ? '0 : s_mag * s_mag;
    end
    adx_q <= dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
    ady_q <= dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
    a1_q  <= {y_q, x_q};
    dx2_q <= adx_q * adx_q;
    dy2_q <= ady_q * ady_q;
    a2_q  <= a1_q;
    d2_q  <= {1'b0, dx2_q} + {1'b0, dy2_q};
    a3_q  <= a2_q;
    if (load_out) begin
      out_word_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      canvas_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= canvas_mem[rd_addr];
    end
  end

  assign stat_o.pop      = pop;
  assign stat_o.clearing = (state_q == ST_CLEAR);
  assign out_valid_o     = out_valid_q;
  assign out_word_o      = out_word_q;

endmodule

[design/circle_raster_canvas.sv]
// With the queue empty and the back end idle: a read result comes from a registered
// canvas read, a rejected or blocked word gets its status from the queue head; a draw
// sweeps the area in use (none for an empty area), one pixel per cycle through the distance pipeline and write port.
// The back end handles one word at a time and pops the next only when idle with no
// result pending; the queue holds up to two words meanwhile. Reset: a clearing pass zeroes
// the 65536-entry canvas with no word accepted; configuration writes are taken throughout.
module circle_raster_canvas (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  crc_pkg::in_word_t                   in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output crc_pkg::out_word_t                  out_word_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [crc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [crc_pkg::SIZE_W-1:0]          cfg_data_i
);
  import crc_pkg::*;

  cfg_t       cfg_q;
  back_stat_t stat;
  q_entry_t   head;
  logic       head_valid;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= SIZE_RESET;
      cfg_q.height <= SIZE_RESET;
      cfg_q.bg     <= BG_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_WIDTH:  cfg_q.width  <= cfg_data_i;
        CFG_HEIGHT: cfg_q.height <= cfg_data_i;
        CFG_BG:     cfg_q.bg     <= cfg_data_i[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  crc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .stat_i       (stat),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  crc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_i       (head),
    .head_valid_i (head_valid),
    .stat_o       (stat),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

endmodule
